/* rtl/pchc_pkg.sv */
// ----------------------------------------------------------------------------
// pchc_pkg
// Shared types, constants and helpers for the printable character histogram.
// ----------------------------------------------------------------------------
package pchc_pkg;

    localparam int NUM_BINS    = 95;
    localparam int COUNT_WIDTH = 16;
    localparam int ADDR_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int IDX_W       = 7;
    localparam int BYTE_BITS   = 8;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_ABORT = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HDR_HI,
        PH_HDR_LO,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_BYTE,
        CMD_QUERY
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic             printable;
        logic             commit;
        logic [IDX_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_INC,
        BK_WALK,
        BK_WDONE,
        BK_QUERY,
        BK_REPLY
    } back_state_t;

    function automatic logic in_range(logic [IDX_W-1:0] idx);
        return 9'(idx) < 9'(NUM_BINS);
    endfunction

    function automatic logic [15:0] to_reply(count_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

endpackage

/* rtl/printable_char_histogram_counter.sv */
// ----------------------------------------------------------------------------
// printable_char_histogram_counter
// Per-connection printable character histogram with global bins.
// ----------------------------------------------------------------------------
// Input stream (s_*): tuser carries the action (start, stream byte, abort,
// global bin query), tdata the stream byte and the queried bin index.
// Output stream (m_*): tuser says whether tdata is the printable count of a
// finished connection or the value of a global bin.
// The front tracks the 16-bit big-endian header and the payload length and
// posts commands into a four-entry queue; the back executes them.
// A printable payload byte costs the back end a read-modify-write of its
// connection bin; any other payload byte is only popped. A commit walks all
// NUM_BINS bins, one per cycle, and its reply then passes the BK_WDONE and
// BK_REPLY states; a query reply passes the BK_QUERY and BK_REPLY states.
// Reset clears all bins at once through per-bin valid flops; no clearing pass.
// When m_tready is low the reply stays in the output register; the back then
// stalls on its next reply, the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module printable_char_histogram_counter
    import pchc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] data_byte, [14:8] bin_index, [15] zero
    input  logic [1:0]  s_tuser,    // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] reply_value
    output logic [0:0]  m_tuser     // [0] reply_kind
);

    queue_status_t qstat;
    logic          push;
    logic          pop;
    cmd_t          push_cmd;
    cmd_t          head;
    logic          kind;

    pchc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (s_tuser),
        .data_byte (s_tdata[7:0]),
        .bin_index (s_tdata[14:8]),
        .qstat     (qstat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    pchc_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    pchc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .reply_kind  (kind),
        .reply_value (m_tdata)
    );

    assign m_tuser = kind;

endmodule

/* rtl/pchc_front.sv */
// ----------------------------------------------------------------------------
// pchc_front
// Accepts input requests, tracks the frame header and length, and turns start,
// abort, query, payload byte and zero-length header requests into back-end commands.
// ----------------------------------------------------------------------------
module pchc_front
    import pchc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       action,
    input  logic [7:0]       data_byte,
    input  logic [IDX_W-1:0] bin_index,
    input  queue_status_t    qstat,
    output logic             push,
    output cmd_t             push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic        accept;
    logic [15:0] hdr_len;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign hdr_len  = left_reg | 16'(data_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        if (accept)
        begin
            unique case (action_t'(action))
                ACT_START:
                begin
                    phase_next = PH_HDR_HI;
                    left_next  = '0;
                end
                ACT_ABORT:
                begin
                    phase_next = PH_IDLE;
                    left_next  = '0;
                end
                ACT_QUERY: ;
                ACT_BYTE:
                begin
                    unique case (phase_reg)
                        PH_IDLE: ;
                        PH_HDR_HI:
                        begin
                            left_next  = 16'(data_byte) << BYTE_BITS;
                            phase_next = PH_HDR_LO;
                        end
                        PH_HDR_LO:
                        begin
                            left_next  = hdr_len;
                            phase_next = (hdr_len == 16'd0) ? PH_IDLE : PH_BODY;
                        end
                        PH_BODY:
                        begin
                            left_next = left_reg - 16'd1;
                            if (left_reg == 16'd1)
                                phase_next = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // command generation
    always_comb
    begin
        push               = 1'b0;
        push_cmd.op        = CMD_CLEAR;
        push_cmd.printable = 1'b0;
        push_cmd.commit    = 1'b0;
        push_cmd.index     = bin_index;
        if (accept)
        begin
            unique case (action_t'(action))
                ACT_START, ACT_ABORT:
                    push = 1'b1;
                ACT_QUERY:
                begin
                    push        = 1'b1;
                    push_cmd.op = CMD_QUERY;
                end
                ACT_BYTE:
                begin
                    push_cmd.op = CMD_BYTE;
                    if (phase_reg == PH_HDR_LO && hdr_len == 16'd0)
                    begin
                        push            = 1'b1;
                        push_cmd.commit = 1'b1;
                    end
                    else if (phase_reg == PH_BODY)
                    begin
                        push               = 1'b1;
                        push_cmd.printable = (data_byte >= PRINT_LO) && (data_byte <= PRINT_HI);
                        push_cmd.commit    = (left_reg == 16'd1);
                        push_cmd.index     = IDX_W'(data_byte - PRINT_LO);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/pchc_cmd_queue.sv */
// ----------------------------------------------------------------------------
// pchc_cmd_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module pchc_cmd_queue
    import pchc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t qstat
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              do_push, do_pop;

    assign qstat.full  = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/pchc_back.sv */
// ----------------------------------------------------------------------------
// pchc_back
// Executes commands: connection clears and bin updates, the commit walk into the global
// bins, global bin reads, and the registered reply output.
// ----------------------------------------------------------------------------
module pchc_back
    import pchc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t qstat,
    input  cmd_t          head,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic          reply_kind,
    output logic [15:0]   reply_value
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    count_t            cnt_reg, cnt_next;
    logic [ADDR_W-1:0] walk_reg, walk_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;
    logic              pend_reg, pend_next;
    logic              rep_kind_reg, rep_kind_next;
    logic [15:0]       rep_val_reg, rep_val_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [15:0]       out_value_reg, out_value_next;
    logic [NUM_BINS-1:0] cvld_reg, cvld_next;
    logic [NUM_BINS-1:0] gvld_reg, gvld_next;

    count_t            conn_mem [NUM_BINS];
    count_t            gbl_mem  [NUM_BINS];
    count_t            conn_rd_reg, gbl_rd_reg;
    logic              conn_rv_reg, gbl_rv_reg;

    logic [ADDR_W-1:0] conn_ra, gbl_ra, conn_wa, gbl_wa;
    logic              conn_we, gbl_we;
    count_t            conn_wd, gbl_wd;
    count_t            conn_val, gbl_val;
    logic              out_free;

    assign conn_val = conn_rv_reg ? conn_rd_reg : '0;
    assign gbl_val  = gbl_rv_reg ? gbl_rd_reg : '0;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid    = out_valid_reg;
    assign reply_kind  = out_kind_reg;
    assign reply_value = out_value_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    case (head.op)
                        CMD_QUERY:
                            state_next = BK_QUERY;
                        CMD_BYTE:
                        begin
                            if (head.printable && in_range(head.index))
                                state_next = BK_INC;
                            else if (head.commit)
                                state_next = BK_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            BK_INC:
                state_next = cmd_reg.commit ? BK_WALK : BK_IDLE;
            BK_WALK:
                if (walk_reg == LAST_ADDR)
                    state_next = BK_WDONE;
            BK_WDONE:
                state_next = BK_REPLY;
            BK_QUERY:
                state_next = BK_REPLY;
            BK_REPLY:
                if (out_free)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        pop            = 1'b0;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        walk_next      = walk_reg;
        waddr_next     = waddr_reg;
        pend_next      = pend_reg;
        rep_kind_next  = rep_kind_reg;
        rep_val_next   = rep_val_reg;
        cvld_next      = cvld_reg;
        gvld_next      = gvld_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        conn_ra        = ADDR_W'(head.index);
        gbl_ra         = ADDR_W'(head.index);
        conn_we        = 1'b0;
        conn_wa        = ADDR_W'(cmd_reg.index);
        conn_wd        = conn_val + 1'b1;
        gbl_we         = 1'b0;
        gbl_wa         = waddr_reg;
        gbl_wd         = gbl_val + conn_val;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop       = 1'b1;
                    cmd_next  = head;
                    walk_next = '0;
                    pend_next = 1'b0;
                    case (head.op)
                        CMD_CLEAR:
                        begin
                            cvld_next = '0;
                            cnt_next  = '0;
                        end
                        CMD_BYTE:
                            if (head.printable)
                                cnt_next = cnt_reg + 1'b1;
                        default: ;
                    endcase
                end
            end
            BK_INC:
            begin
                conn_we            = 1'b1;
                cvld_next[conn_wa] = 1'b1;
            end
            BK_WALK:
            begin
                conn_ra    = walk_reg;
                gbl_ra     = walk_reg;
                waddr_next = walk_reg;
                pend_next  = 1'b1;
                walk_next  = walk_reg + 1'b1;
                if (pend_reg)
                begin
                    gbl_we            = 1'b1;
                    gvld_next[gbl_wa] = 1'b1;
                end
            end
            BK_WDONE:
            begin
                gbl_we            = 1'b1;
                gvld_next[gbl_wa] = 1'b1;
                rep_kind_next     = 1'b0;
                rep_val_next      = to_reply(cnt_reg);
            end
            BK_QUERY:
            begin
                rep_kind_next = 1'b1;
                rep_val_next  = in_range(cmd_reg.index) ? to_reply(gbl_val) : 16'd0;
            end
            BK_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = rep_kind_reg;
                    out_value_next = rep_val_reg;
                    // drop the finished connection
                    if (!rep_kind_reg)
                    begin
                        cvld_next = '0;
                        cnt_next  = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cvld_reg      <= '0;
            gvld_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            cvld_reg      <= cvld_next;
            gvld_reg      <= gvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        walk_reg      <= walk_next;
        waddr_reg     <= waddr_next;
        rep_kind_reg  <= rep_kind_next;
        rep_val_reg   <= rep_val_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
    end

    always_ff @(posedge clk)
    begin
        if (conn_we)
            conn_mem[conn_wa] <= conn_wd;
        conn_rd_reg <= conn_mem[conn_ra];
        conn_rv_reg <= cvld_reg[conn_ra];
    end

    always_ff @(posedge clk)
    begin
        if (gbl_we)
            gbl_mem[gbl_wa] <= gbl_wd;
        gbl_rd_reg <= gbl_mem[gbl_ra];
        gbl_rv_reg <= gvld_reg[gbl_ra];
    end

endmodule
